/* src/rgb565_bilinear_downscaler_defines.svh */
// Assertion macros for the RGB565 bilinear downscaler.
`ifndef RGB565_BILINEAR_DOWNSCALER_DEFINES_SVH
`define RGB565_BILINEAR_DOWNSCALER_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define RBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define RBD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RBD_ASSERT(label, prop, msg)

`define RBD_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* src/rbd_pkg.sv */
// Shared types and constants of the RGB565 bilinear downscaler.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // Item kind carried on the input tuser bit
    typedef enum logic {
        MODE_WRITE   = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    // Input tdata layout, row in the low byte
    typedef struct packed {
        logic [15:0] pixel;
        logic [7:0]  col;
        logic [7:0]  row;
    } in_data_t;

    // Per-item control carried along the coordinate pipeline
    typedef struct packed {
        logic        req;     // output pixel request
        logic        hit;     // request inside the scaled area
        logic        wr_ok;   // source write inside the image
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] pixel;
    } tag_t;

    // Scale register
    localparam int SCALE_W     = 7;
    localparam int SCALE_CODES = 2 ** SCALE_W;
    localparam int SCALE_MIN   = 1;
    localparam int SCALE_MAX   = 100;

    // RGB565 channel layout
    localparam logic [15:0] RED_MASK = 16'hF800;
    localparam logic [15:0] GRN_MASK = 16'h07E0;
    localparam logic [15:0] BLU_MASK = 16'h001F;
    localparam int RED_LSB = 11;
    localparam int GRN_LSB = 5;
    localparam int RB_W    = 5;
    localparam int G_W     = 6;
    localparam int RB_MAX  = 31;
    localparam int G_MAX   = 63;

    function automatic logic [G_W-1:0] red_of(input logic [15:0] pix);
        red_of = G_W'((pix & RED_MASK) >> RED_LSB);
    endfunction

    function automatic logic [G_W-1:0] grn_of(input logic [15:0] pix);
        grn_of = G_W'((pix & GRN_MASK) >> GRN_LSB);
    endfunction

    function automatic logic [G_W-1:0] blu_of(input logic [15:0] pix);
        blu_of = G_W'(pix & BLU_MASK);
    endfunction

endpackage

`default_nettype wire

/* src/rgb565_bilinear_downscaler.sv */
// Top level of the RGB565 bilinear downscaler with banked source memory.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata row, col, pixel; tuser mode
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata out_pixel; tuser in_region
//  cfg      | in  | cfg_we                         | cfg_data scale_percent
//
//  One transaction per clock unless the output is held, writes and requests mixed freely.
//  A request passes the first stage, NST divider stages and the memory, blend
//  and output registers, NST being clog2(max(ROWS, COLS)) + FRAC_BITS (16 at the defaults).
//  Four source banks split by row and column parity give the four
//  neighbours with reads in the same cycle; the source memory is not cleared on reset.
//  A held output stalls the whole pipe; one skid entry still takes an input.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb565_bilinear_downscaler_defines.svh"

module rgb565_bilinear_downscaler #(
    parameter int ROWS      = 256,
    parameter int COLS      = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // row[7:0], col[15:8], pixel[31:16]
    input  wire logic        s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_pixel[15:0]
    output logic             m_axis_tuser,   // in_region
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_data        // scale_percent
);

    localparam int SW     = rbd_pkg::SCALE_W;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int RHW    = (RW > 1) ? RW - 1 : 1;
    localparam int CHW    = (CW > 1) ? CW - 1 : 1;
    localparam int AW     = RHW + CHW;
    localparam int BANK_DEPTH = 2 ** AW;
    localparam int NST    = ((RW > CW) ? RW : CW) + FRAC_BITS;
    localparam int PIW    = NST - FRAC_BITS;
    localparam int GRW    = RW + 1;
    localparam int GCW    = CW + 1;
    localparam int RPW    = (GRW > 8) ? GRW : 8;
    localparam int CPW    = (GCW > 8) ? GCW : 8;
    localparam int UW     = FRAC_BITS + 1;
    localparam int WW     = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = WW + rbd_pkg::G_W;
    localparam int SUM_SHIFT = 2 * FRAC_BITS;
    localparam int CHW_OUT = ACC_W - SUM_SHIFT;

    localparam logic [PIW-1:0] ROW_LAST = PIW'(ROWS - 1);
    localparam logic [PIW-1:0] COL_LAST = PIW'(COLS - 1);
    localparam logic [UW-1:0]  UNIT     = UW'(2 ** FRAC_BITS);

    // ---------------- input skid and first stage ----------------
    logic                 adv;
    logic                 in_fire;
    logic                 skid_valid_reg;
    rbd_pkg::in_data_t    skid_data_reg;
    logic                 skid_user_reg;
    logic                 s0_valid_reg;
    rbd_pkg::in_data_t    s0_data_reg;
    logic                 s0_user_reg;

    // ---------------- geometry ----------------
    logic [SW-1:0]  scale_tab [rbd_pkg::SCALE_CODES];
    logic [GRW-1:0] rlo_tab   [rbd_pkg::SCALE_CODES];
    logic [GRW-1:0] rhi_tab   [rbd_pkg::SCALE_CODES];
    logic [GCW-1:0] clo_tab   [rbd_pkg::SCALE_CODES];
    logic [GCW-1:0] chi_tab   [rbd_pkg::SCALE_CODES];
    logic [SW-1:0]  scale_reg;
    logic [GRW-1:0] rlo_reg;
    logic [GRW-1:0] rhi_reg;
    logic [GCW-1:0] clo_reg;
    logic [GCW-1:0] chi_reg;

    // ---------------- region test ----------------
    logic [RPW-1:0]  row_ext;
    logic [CPW-1:0]  col_ext;
    logic            row_in;
    logic            col_in;
    logic            is_req;
    rbd_pkg::tag_t   s0_tag;
    logic [RW-1:0]   s0_j;
    logic [CW-1:0]   s0_k;

    // ---------------- divider output ----------------
    logic            d_valid;
    rbd_pkg::tag_t   d_tag;
    logic [NST-1:0]  d_p;
    logic [NST-1:0]  d_q;

    // ---------------- memory stage ----------------
    logic [PIW-1:0]  p0_raw;
    logic [PIW-1:0]  q0_raw;
    logic [RW-1:0]   p0c;
    logic [RW-1:0]   p1c;
    logic [CW-1:0]   q0c;
    logic [CW-1:0]   q1c;
    logic [FRAC_BITS-1:0] frac_a;
    logic [FRAC_BITS-1:0] frac_b;
    logic [UW-1:0]   oma;
    logic [UW-1:0]   omb;
    logic [WW-1:0]   w_next   [4];
    logic [1:0]      sel_next [4];
    logic [AW-1:0]   rd_addr  [4];
    logic [3:0]      wr_en;
    logic [RW-1:0]   wr_row;
    logic [CW-1:0]   wr_col;
    logic [AW-1:0]   wr_addr;
    logic [15:0]     rd_data_reg [4];
    logic            m_valid_reg;
    logic            m_req_reg;
    logic            m_hit_reg;
    logic [1:0]      sel_reg [4];
    logic [WW-1:0]   w_reg   [4];

    // ---------------- blend stage ----------------
    logic [15:0]      nb [4];
    logic [ACC_W-1:0] acc_r_next;
    logic [ACC_W-1:0] acc_g_next;
    logic [ACC_W-1:0] acc_b_next;
    logic             x_valid_reg;
    logic             x_req_reg;
    logic             x_hit_reg;
    logic [ACC_W-1:0] acc_r_reg;
    logic [ACC_W-1:0] acc_g_reg;
    logic [ACC_W-1:0] acc_b_reg;

    // ---------------- output ----------------
    logic [CHW_OUT-1:0]       red_sh;
    logic [CHW_OUT-1:0]       grn_sh;
    logic [CHW_OUT-1:0]       blu_sh;
    logic [rbd_pkg::RB_W-1:0] red_lim;
    logic [rbd_pkg::G_W-1:0]  grn_lim;
    logic [rbd_pkg::RB_W-1:0] blu_lim;
    logic [15:0]              pix_next;
    logic                     out_valid_reg;
    logic [15:0]              out_pixel_reg;
    logic                     out_region_reg;

    // Whole pipe moves unless a result is held at the output
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Skid and first stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            s0_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg   <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Skid and first stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (skid_valid_reg)
            begin
                s0_data_reg <= skid_data_reg;
                s0_user_reg <= skid_user_reg;
            end
            else
            begin
                s0_data_reg <= rbd_pkg::in_data_t'(s_axis_tdata);
                s0_user_reg <= s_axis_tuser;
            end
        end
        if (!adv && in_fire)
        begin
            skid_data_reg <= rbd_pkg::in_data_t'(s_axis_tdata);
            skid_user_reg <= s_axis_tuser;
        end
    end

    // Geometry per scale code, worked out at elaboration
    for (genvar g = 0; g < rbd_pkg::SCALE_CODES; g++)
    begin : g_geo
        localparam int SG  = (g < rbd_pkg::SCALE_MIN) ? rbd_pkg::SCALE_MIN :
                             ((g > rbd_pkg::SCALE_MAX) ? rbd_pkg::SCALE_MAX : g);
        localparam int SHG = ROWS * SG / rbd_pkg::SCALE_MAX;
        localparam int SWG = COLS * SG / rbd_pkg::SCALE_MAX;
        localparam int OHG = (ROWS - SHG) / 2;
        localparam int OWG = (COLS - SWG) / 2;
        assign scale_tab[g] = SW'(SG);
        assign rlo_tab[g]   = GRW'(OHG);
        assign rhi_tab[g]   = GRW'(OHG + SHG);
        assign clo_tab[g]   = GCW'(OWG);
        assign chi_tab[g]   = GCW'(OWG + SWG);
    end

    // Scale register and the window it implies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SW'(rbd_pkg::SCALE_MAX);
            rlo_reg   <= '0;
            rhi_reg   <= GRW'(ROWS);
            clo_reg   <= '0;
            chi_reg   <= GCW'(COLS);
        end
        else if (cfg_we)
        begin
            scale_reg <= scale_tab[cfg_data];
            rlo_reg   <= rlo_tab[cfg_data];
            rhi_reg   <= rhi_tab[cfg_data];
            clo_reg   <= clo_tab[cfg_data];
            chi_reg   <= chi_tab[cfg_data];
        end
    end

    // Region test and offset into the scaled area
    always_comb
    begin
        row_ext = RPW'(s0_data_reg.row);
        col_ext = CPW'(s0_data_reg.col);
        row_in  = (row_ext >= RPW'(rlo_reg)) && (row_ext < RPW'(rhi_reg));
        col_in  = (col_ext >= CPW'(clo_reg)) && (col_ext < CPW'(chi_reg));
        is_req  = (s0_user_reg == rbd_pkg::MODE_REQUEST);
        s0_tag.req   = is_req;
        s0_tag.hit   = is_req && row_in && col_in;
        s0_tag.wr_ok = !is_req && (row_ext < RPW'(ROWS)) && (col_ext < CPW'(COLS));
        s0_tag.row   = s0_data_reg.row;
        s0_tag.col   = s0_data_reg.col;
        s0_tag.pixel = s0_data_reg.pixel;
        s0_j = RW'(row_ext - RPW'(rlo_reg));
        s0_k = CW'(col_ext - CPW'(clo_reg));
    end

    rbd_coord_div #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s0_valid_reg),
        .in_tag    (s0_tag),
        .in_j      (s0_j),
        .in_k      (s0_k),
        .scale     (scale_reg),
        .out_valid (d_valid),
        .out_tag   (d_tag),
        .out_p     (d_p),
        .out_q     (d_q)
    );

    // Neighbour indices with edge clamp, and blend weights
    always_comb
    begin
        p0_raw = PIW'(d_p >> FRAC_BITS);
        q0_raw = PIW'(d_q >> FRAC_BITS);
        p0c    = (p0_raw > ROW_LAST) ? RW'(ROWS - 1) : RW'(p0_raw);
        q0c    = (q0_raw > COL_LAST) ? CW'(COLS - 1) : CW'(q0_raw);
        p1c    = (p0c == RW'(ROWS - 1)) ? p0c : RW'(p0c + 1'b1);
        q1c    = (q0c == CW'(COLS - 1)) ? q0c : CW'(q0c + 1'b1);
        frac_a = d_p[FRAC_BITS-1:0];
        frac_b = d_q[FRAC_BITS-1:0];
        oma    = UNIT - UW'(frac_a);
        omb    = UNIT - UW'(frac_b);
        // order: (p0,q0), (p1,q0), (p0,q1), (p1,q1)
        w_next[0]   = WW'(oma) * WW'(omb);
        w_next[1]   = WW'(frac_a) * WW'(omb);
        w_next[2]   = WW'(oma) * WW'(frac_b);
        w_next[3]   = WW'(frac_a) * WW'(frac_b);
        sel_next[0] = {p0c[0], q0c[0]};
        sel_next[1] = {p1c[0], q0c[0]};
        sel_next[2] = {p0c[0], q1c[0]};
        sel_next[3] = {p1c[0], q1c[0]};
    end

    // Bank addresses: bank {row parity, col parity} holds the neighbour of that parity
    always_comb
    begin : bank_addr
        logic [RW-1:0] rsel;
        logic [CW-1:0] csel;
        logic [1:0]    bsel;
        wr_row  = RW'(d_tag.row);
        wr_col  = CW'(d_tag.col);
        wr_addr = {RHW'(wr_row >> 1), CHW'(wr_col >> 1)};
        for (int bi = 0; bi < 4; bi++)
        begin
            bsel        = 2'(bi);
            rsel        = (p0c[0] == bsel[1]) ? p0c : p1c;
            csel        = (q0c[0] == bsel[0]) ? q0c : q1c;
            rd_addr[bi] = {RHW'(rsel >> 1), CHW'(csel >> 1)};
            wr_en[bi]   = d_valid && d_tag.wr_ok && ({d_tag.row[0], d_tag.col[0]} == bsel);
        end
    end

    // Source banks; writes and reads sit in the same stage so program order holds
    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        logic [15:0] mem [BANK_DEPTH];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (wr_en[gb])
                begin
                    mem[wr_addr] <= d_tag.pixel;
                end
                rd_data_reg[gb] <= mem[rd_addr[gb]];
            end
        end
    end

    // Memory, blend and output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= d_valid;
            x_valid_reg   <= m_valid_reg;
            out_valid_reg <= x_valid_reg && x_req_reg;
        end
    end

    // Memory stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_req_reg <= d_tag.req;
            m_hit_reg <= d_tag.hit;
            for (int i = 0; i < 4; i++)
            begin
                sel_reg[i] <= sel_next[i];
                w_reg[i]   <= w_next[i];
            end
        end
    end

    // Weighted sums per channel
    always_comb
    begin
        acc_r_next = '0;
        acc_g_next = '0;
        acc_b_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            nb[i]      = rd_data_reg[sel_reg[i]];
            acc_r_next = acc_r_next + ACC_W'(w_reg[i]) * ACC_W'(rbd_pkg::red_of(nb[i]));
            acc_g_next = acc_g_next + ACC_W'(w_reg[i]) * ACC_W'(rbd_pkg::grn_of(nb[i]));
            acc_b_next = acc_b_next + ACC_W'(w_reg[i]) * ACC_W'(rbd_pkg::blu_of(nb[i]));
        end
    end

    // Blend stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_req_reg <= m_req_reg;
            x_hit_reg <= m_hit_reg;
            acc_r_reg <= acc_r_next;
            acc_g_reg <= acc_g_next;
            acc_b_reg <= acc_b_next;
        end
    end

    // Truncate, limit and pack; black outside the scaled area
    always_comb
    begin
        red_sh  = CHW_OUT'(acc_r_reg >> SUM_SHIFT);
        grn_sh  = CHW_OUT'(acc_g_reg >> SUM_SHIFT);
        blu_sh  = CHW_OUT'(acc_b_reg >> SUM_SHIFT);
        red_lim = (red_sh > CHW_OUT'(rbd_pkg::RB_MAX)) ? rbd_pkg::RB_W'(rbd_pkg::RB_MAX)
                                                       : rbd_pkg::RB_W'(red_sh);
        grn_lim = (grn_sh > CHW_OUT'(rbd_pkg::G_MAX)) ? rbd_pkg::G_W'(rbd_pkg::G_MAX)
                                                      : rbd_pkg::G_W'(grn_sh);
        blu_lim = (blu_sh > CHW_OUT'(rbd_pkg::RB_MAX)) ? rbd_pkg::RB_W'(rbd_pkg::RB_MAX)
                                                       : rbd_pkg::RB_W'(blu_sh);
        pix_next = x_hit_reg ? {red_lim, grn_lim, blu_lim} : 16'd0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pixel_reg  <= pix_next;
            out_region_reg <= x_hit_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tuser  = out_region_reg;

    // Checks
    `RBD_ASSERT(a_req_reaches_out, adv && x_valid_reg && x_req_reg |=> m_axis_tvalid, "request lost before output")
    `RBD_ASSERT(a_border_black, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0, "border pixel not black")
    `RBD_ASSERT(a_coord_in_image, d_valid && d_tag.hit |-> (p0_raw <= ROW_LAST) && (q0_raw <= COL_LAST), "source coordinate beyond image")
    `RBD_ASSERT(a_skid_kept, skid_valid_reg && !adv |=> skid_valid_reg, "skid entry dropped while stalled")

endmodule

`default_nettype wire

/* src/rbd_coord_div.sv */
// Pipelined restoring divider giving fixed-point source row and column.
`timescale 1ns / 1ps
`default_nettype none

module rbd_coord_div #(
    parameter int ROWS      = 256,
    parameter int COLS      = 256,
    parameter int FRAC_BITS = 8,
    localparam int RW  = $clog2(ROWS),
    localparam int CW  = $clog2(COLS),
    localparam int NST = ((RW > CW) ? RW : CW) + FRAC_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire rbd_pkg::tag_t               in_tag,
    input  wire logic [RW-1:0]               in_j,
    input  wire logic [CW-1:0]               in_k,
    input  wire logic [rbd_pkg::SCALE_W-1:0] scale,
    output logic                             out_valid,
    output rbd_pkg::tag_t                    out_tag,
    output logic [NST-1:0]                   out_p,
    output logic [NST-1:0]                   out_q
);

    localparam int SW  = rbd_pkg::SCALE_W;
    localparam int MRW = RW + SW;
    localparam int MCW = CW + SW;
    localparam int NRW = MRW + FRAC_BITS;
    localparam int NCW = MCW + FRAC_BITS;

    logic [NST-1:0]   vld_reg;
    rbd_pkg::tag_t    tag_reg   [NST];
    logic [SW-1:0]    rem_p_reg [NST];
    logic [NST-1:0]   quo_p_reg [NST];
    logic [SW-1:0]    rem_q_reg [NST];
    logic [NST-1:0]   quo_q_reg [NST];
    logic [SW-1:0]    rem_p_next [NST];
    logic [NST-1:0]   quo_p_next [NST];
    logic [SW-1:0]    rem_q_next [NST];
    logic [NST-1:0]   quo_q_next [NST];

    logic [MRW-1:0]   prod_j;
    logic [MCW-1:0]   prod_k;
    logic [NRW-1:0]   num_p;
    logic [NCW-1:0]   num_q;

    // One quotient bit: shift in the next dividend bit, subtract if it fits
    function automatic logic [SW+NST-1:0] div_step(
        input logic [SW-1:0]  rem,
        input logic [NST-1:0] low,
        input logic [SW-1:0]  s
    );
        logic [SW:0] t;
        logic        ge;
        t  = {rem, low[NST-1]};
        ge = (t >= {1'b0, s});
        div_step = {(ge ? SW'(t - {1'b0, s}) : t[SW-1:0]), low[NST-2:0], ge};
    endfunction

    // Dividend = coordinate * 100 * 2^FRAC_BITS; the quotient fits NST bits
    assign prod_j = MRW'(in_j) * MRW'(rbd_pkg::SCALE_MAX);
    assign prod_k = MCW'(in_k) * MCW'(rbd_pkg::SCALE_MAX);
    assign num_p  = {prod_j, FRAC_BITS'(0)};
    assign num_q  = {prod_k, FRAC_BITS'(0)};

    // Next value of every stage
    always_comb
    begin : stage_logic
        logic [SW-1:0]  rin_p;
        logic [NST-1:0] lin_p;
        logic [SW-1:0]  rin_q;
        logic [NST-1:0] lin_q;
        for (int i = 0; i < NST; i++)
        begin
            if (i == 0)
            begin
                rin_p = SW'(num_p >> NST);
                lin_p = NST'(num_p);
                rin_q = SW'(num_q >> NST);
                lin_q = NST'(num_q);
            end
            else
            begin
                rin_p = rem_p_reg[i-1];
                lin_p = quo_p_reg[i-1];
                rin_q = rem_q_reg[i-1];
                lin_q = quo_q_reg[i-1];
            end
            {rem_p_next[i], quo_p_next[i]} = div_step(rin_p, lin_p, scale);
            {rem_q_next[i], quo_q_next[i]} = div_step(rin_q, lin_q, scale);
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NST; i++)
            begin
                tag_reg[i]   <= (i == 0) ? in_tag : tag_reg[(i == 0) ? 0 : i - 1];
                rem_p_reg[i] <= rem_p_next[i];
                quo_p_reg[i] <= quo_p_next[i];
                rem_q_reg[i] <= rem_q_next[i];
                quo_q_reg[i] <= quo_q_next[i];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_tag   = tag_reg[NST-1];
    assign out_p     = quo_p_reg[NST-1];
    assign out_q     = quo_q_reg[NST-1];

endmodule

`default_nettype wire

/* verif/rgb565_bilinear_downscaler_test.sv */
// Self-checking stream testbench for the RGB565 bilinear downscaler.
`timescale 1ns / 1ps

module rgb565_bilinear_downscaler_test;

    localparam int NROWS     = 256;
    localparam int NCOLS     = 256;
    localparam int FRAC      = 8;
    localparam int SETTLE    = 40;
    localparam int LIMIT     = 200000;
    localparam int RUN_ITEMS = 175;
    localparam int NRUNS     = 8;

    // One input transaction waiting to be driven
    typedef struct {
        rbd_pkg::mode_t mode;
        logic [7:0]     row;
        logic [7:0]     col;
        logic [15:0]    pixel;
    } pixel_op_t;

    // One expected output pixel
    typedef struct {
        logic [15:0] pix;
        logic        inreg;
        logic [7:0]  row;
        logic [7:0]  col;
    } out_pixel_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we        = 1'b0;
    logic [6:0]  cfg_data      = '0;

    // Stimulus plan: ops to drive, and which source entries they will have written
    pixel_op_t   op_q[$];
    logic [6:0]  plan_scale = 7'd100;
    bit          planned [NROWS*NCOLS];
    int          queued_ops = 0;

    // Shadow of the block: source image, scale register, pending results
    logic [15:0] src_img [NROWS*NCOLS];
    logic [6:0]  scale_reg = 7'd100;
    out_pixel_t  pixel_q[$];

    bit          in_taken = 1'b0;
    bit          no_gaps  = 1'b0;
    int          errors   = 0;
    int          cycles   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb565_bilinear_downscaler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // row[7:0], col[15:8], pixel[31:16]
        .s_axis_tuser  (s_axis_tuser),   // mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_pixel[15:0]
        .m_axis_tuser  (m_axis_tuser),   // in_region
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)        // scale_percent
    );

    // Scaled area for a register value; 0 acts as 1, above 100 as 100
    function automatic void scaled_area(input logic [6:0] reg_val, output int unsigned s,
                                        output int unsigned sh, output int unsigned sw,
                                        output int unsigned oh, output int unsigned ow);
        s = reg_val;
        if (s < 1)
            s = 1;
        if (s > 100)
            s = 100;
        sh = NROWS * s / 100;
        sw = NCOLS * s / 100;
        oh = (NROWS - sh) / 2;
        ow = (NCOLS - sw) / 2;
    endfunction

    // Source position along one axis: neighbour pair (clamped) and fraction
    function automatic void src_axis(input int unsigned off, input int unsigned s,
                                     input int unsigned lim, output int unsigned n0,
                                     output int unsigned n1, output int unsigned frac);
        int unsigned fx;
        fx   = ((off * 100) << FRAC) / s;
        n0   = fx >> FRAC;
        frac = fx & ((1 << FRAC) - 1);
        n1   = n0 + 1;
        if (n0 > lim - 1)
            n0 = lim - 1;
        if (n1 > lim - 1)
            n1 = lim - 1;
    endfunction

    // Bilinear blend of one color channel; a weights the row neighbour, b the column one
    function automatic int unsigned mix_channel(input logic [15:0] n00, input logic [15:0] n10,
                                                input logic [15:0] n01, input logic [15:0] n11,
                                                input int unsigned a, input int unsigned b,
                                                input int lsb, input int width);
        int unsigned one, lim, acc;
        one = 1 << FRAC;
        lim = (1 << width) - 1;
        acc = (one - a) * (one - b) * ((n00 >> lsb) & lim)
            + a * (one - b) * ((n10 >> lsb) & lim)
            + (one - a) * b * ((n01 >> lsb) & lim)
            + a * b * ((n11 >> lsb) & lim);
        acc = acc >> (2 * FRAC);
        return (acc > lim) ? lim : acc;
    endfunction

    // Expected output pixel for a request at output position (r, c)
    function automatic out_pixel_t downscaled_pixel(input logic [7:0] r, input logic [7:0] c);
        int unsigned s, sh, sw, oh, ow, p0, p1, q0, q1, a, b;
        logic [15:0] n00, n10, n01, n11;
        out_pixel_t res;
        res.row   = r;
        res.col   = c;
        res.pix   = '0;
        res.inreg = 1'b0;
        scaled_area(scale_reg, s, sh, sw, oh, ow);
        if (r < oh || r >= oh + sh || c < ow || c >= ow + sw)
            return res;
        src_axis(r - oh, s, NROWS, p0, p1, a);
        src_axis(c - ow, s, NCOLS, q0, q1, b);
        n00 = src_img[p0*NCOLS + q0];
        n10 = src_img[p1*NCOLS + q0];
        n01 = src_img[p0*NCOLS + q1];
        n11 = src_img[p1*NCOLS + q1];
        res.pix = 16'((mix_channel(n00, n10, n01, n11, a, b, rbd_pkg::RED_LSB, rbd_pkg::RB_W)
                       << rbd_pkg::RED_LSB)
                    | (mix_channel(n00, n10, n01, n11, a, b, rbd_pkg::GRN_LSB, rbd_pkg::G_W)
                       << rbd_pkg::GRN_LSB)
                    |  mix_channel(n00, n10, n01, n11, a, b, 0, rbd_pkg::RB_W));
        res.inreg = 1'b1;
        return res;
    endfunction

    // Update the shadow image or queue an expected pixel for one accepted transaction
    function automatic void absorb_op(input logic [31:0] data, input logic user);
        rbd_pkg::in_data_t d;
        d = rbd_pkg::in_data_t'(data);
        if (rbd_pkg::mode_t'(user) == rbd_pkg::MODE_WRITE)
            src_img[d.row*NCOLS + d.col] = d.pixel;
        else
            pixel_q.push_back(downscaled_pixel(d.row, d.col));
    endfunction

    // Random pixel, with the all-zero and all-one values now and then
    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void push_op(input rbd_pkg::mode_t m, input int unsigned r,
                                    input int unsigned c, input logic [15:0] pix);
        pixel_op_t op;
        op.mode  = m;
        op.row   = 8'(r);
        op.col   = 8'(c);
        op.pixel = pix;
        op_q.push_back(op);
        queued_ops++;
    endfunction

    function automatic void queue_write(input int unsigned r, input int unsigned c,
                                        input logic [15:0] pix);
        push_op(rbd_pkg::MODE_WRITE, r, c, pix);
        planned[r*NCOLS + c] = 1'b1;
    endfunction

    function automatic void ensure_written(input int unsigned r, input int unsigned c);
        if (!planned[r*NCOLS + c])
            queue_write(r, c, rand_pixel());
    endfunction

    // Request one output pixel, writing first any neighbour it reads that is still unset
    function automatic void queue_request(input int unsigned r, input int unsigned c);
        int unsigned s, sh, sw, oh, ow, p0, p1, q0, q1, a, b;
        scaled_area(plan_scale, s, sh, sw, oh, ow);
        if (r >= oh && r < oh + sh && c >= ow && c < ow + sw)
        begin
            src_axis(r - oh, s, NROWS, p0, p1, a);
            src_axis(c - ow, s, NCOLS, q0, q1, b);
            ensure_written(p0, q0);
            ensure_written(p1, q0);
            ensure_written(p0, q1);
            ensure_written(p1, q1);
        end
        push_op(rbd_pkg::MODE_REQUEST, r, c, rand_pixel());
    endfunction

    // Mostly raster runs inside the scaled area, plus border hits, stray writes, odd requests
    function automatic void queue_random_run(input int n);
        int unsigned s, sh, sw, oh, ow, r, c, len, pick, tries;
        int start;
        start = queued_ops;
        scaled_area(plan_scale, s, sh, sw, oh, ow);
        while (queued_ops - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                r   = oh + $urandom_range(0, sh - 1);
                c   = ow + $urandom_range(0, sw - 1);
                len = $urandom_range(1, 12);
                for (int k = 0; k < len && c + k < ow + sw; k++)
                    queue_request(r, c + k);
            end
            else if (pick < 70)
            begin
                tries = 0;
                do
                begin
                    r = $urandom_range(0, NROWS - 1);
                    c = $urandom_range(0, NCOLS - 1);
                    tries++;
                end
                while (r >= oh && r < oh + sh && c >= ow && c < ow + sw && tries < 200);
                queue_request(r, c);
            end
            else if (pick < 85)
                queue_write($urandom_range(0, NROWS - 1), $urandom_range(0, NCOLS - 1),
                            rand_pixel());
            else
                queue_request($urandom_range(0, NROWS - 1), $urandom_range(0, NCOLS - 1));
        end
    endfunction

    // Scale register write; only called while the block is idle
    task automatic set_scale(input logic [6:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        plan_scale = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every op is accepted and every result is back, then let the pipe empty
    task automatic drain();
        while (op_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Input driver: next op at the falling edge, with random gaps unless no_gaps is set
    always @(negedge clk)
    begin : drive_input
        pixel_op_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (op_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10))
            begin
                nxt = op_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.pixel, nxt.col, nxt.row};
                s_axis_tuser  <= nxt.mode;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // Output back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end

    // Monitor: config writes, accepted inputs and results, all at the rising edge
    always @(posedge clk)
    begin : watch
        out_pixel_t exp_px;
        if (rst_n)
        begin
            if (cfg_we)
                scale_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_taken = 1'b1;
                absorb_op(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: result with nothing pending: pixel %h in_region %b",
                             $realtime, m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    exp_px = pixel_q.pop_front();
                    if (m_axis_tdata !== exp_px.pix)
                    begin
                        $display("%0t: out_pixel at (%0d,%0d): expected %h, actual %h",
                                 $realtime, exp_px.row, exp_px.col, exp_px.pix, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== exp_px.inreg)
                    begin
                        $display("%0t: in_region at (%0d,%0d): expected %b, actual %b",
                                 $realtime, exp_px.row, exp_px.col, exp_px.inreg,
                                 m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("rgb565_bilinear_downscaler_test: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [6:0] run_scale [NRUNS];
        run_scale = '{7'd0, 7'd127, 7'd50, 7'd37, 7'd99, 7'd100, 7'd2, 7'd63};
        run_scale[NRUNS-1] = 7'($urandom_range(3, 98));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full size after reset: corners, clamping at the last row and column
        queue_write(0, 0, 16'hFFFF);
        queue_write(1, 0, 16'h0000);
        queue_write(0, 1, 16'hF81F);
        queue_write(1, 1, 16'h07E0);
        queue_request(0, 0);
        queue_write(255, 255, 16'hFFFF);
        queue_request(255, 255);
        queue_request(255, 0);
        queue_request(0, 255);
        drain();

        // Smallest scale: a 2x2 area in the middle, border on every side of it
        set_scale(7'd1);
        queue_request(127, 127);
        queue_request(128, 128);
        queue_request(127, 128);
        queue_request(126, 127);
        queue_request(128, 129);
        queue_request(0, 0);
        queue_request(255, 255);
        drain();

        // Random runs over several scales, out-of-range codes included
        for (int i = 0; i < NRUNS; i++)
        begin
            set_scale(run_scale[i]);
            no_gaps = (i == 2);
            queue_random_run(RUN_ITEMS);
            drain();
        end

        if (errors == 0)
            $display("rgb565_bilinear_downscaler_test: PASS");
        else
            $display("rgb565_bilinear_downscaler_test: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/rbd_pkg.sv
src/rbd_coord_div.sv
src/rgb565_bilinear_downscaler.sv
verif/rgb565_bilinear_downscaler_test.sv
